>>> rtl/h2u_pkg.sv
// Shared pixel types and constants for the half-float to unorm8 converter.
`default_nettype none

package h2u_pkg;

  localparam int unsigned HALF_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned EXP_W   = 5;
  localparam int unsigned MANT_W  = 10;
  // Widths of the scaled significand and of the value after the rounding bias.
  localparam int unsigned PROD_W  = 19;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned QUOT_W  = 13;

  localparam logic [EXP_W-1:0]  HALF_EXP_ALL_ONES = 5'h1F;
  localparam logic [EXP_W-1:0]  HALF_EXP_ONE      = 5'd15;
  localparam logic [EXP_W-1:0]  HALF_EXP_ZERO     = 5'd0;
  localparam logic [EXP_W-1:0]  SHIFT_BASE        = 5'd25;
  localparam logic [BYTE_W-1:0] UNORM8_MAX        = 8'd255;

  typedef struct packed {
    logic [HALF_W-1:0] red_half;
    logic [HALF_W-1:0] green_half;
    logic [HALF_W-1:0] blue_half;
    logic [HALF_W-1:0] alpha_half;
  } h2u_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red_byte;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] blue_byte;
    logic [BYTE_W-1:0] alpha_byte;
  } h2u_out_t;

  // Load enables of the three pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } h2u_adv_t;

endpackage

`default_nettype wire

>>> rtl/h2u_lane.sv
// Three-stage datapath that converts one binary16 channel to an 8-bit unorm value.
`default_nettype none

module h2u_lane (
  input  wire logic                          clk,
  input  wire h2u_pkg::h2u_adv_t             adv,
  input  wire logic [h2u_pkg::HALF_W-1:0]    half_i,
  output logic      [h2u_pkg::BYTE_W-1:0]    byte_o
);
  import h2u_pkg::*;

  typedef enum logic [1:0] {
    CLS_NORM,
    CLS_ZERO,
    CLS_SAT
  } cls_t;

  logic              sign_w;
  logic [EXP_W-1:0]  ex_w;
  logic [MANT_W-1:0] mant_w;
  logic              nan_w;
  logic [10:0]       sig_w;
  cls_t              cls_nxt;
  logic [PROD_W-1:0] prod_nxt;
  logic [EXP_W-1:0]  shift_nxt;

  cls_t              cls1_r;
  logic [PROD_W-1:0] prod_r;
  logic [EXP_W-1:0]  shift_r;

  logic [SUM_W-1:0]  bias_w;
  logic [SUM_W-1:0]  sum_w;
  logic [SUM_W-1:0]  shifted_w;
  logic [QUOT_W-1:0] quot_nxt;

  cls_t              cls2_r;
  logic [QUOT_W-1:0] quot_r;

  logic [BYTE_W-1:0] byte_nxt;
  logic [BYTE_W-1:0] byte_r;

  // Stage 1: classify the code and scale the significand by 255.
  always_comb begin
    sign_w = half_i[HALF_W-1];
    ex_w   = half_i[HALF_W-2:MANT_W];
    mant_w = half_i[MANT_W-1:0];
    nan_w  = (ex_w == HALF_EXP_ALL_ONES) && (mant_w != '0);
    sig_w  = {1'b1, mant_w};
    if (sign_w || nan_w || (ex_w == HALF_EXP_ZERO)) begin
      cls_nxt = CLS_ZERO;
    end else if (ex_w >= HALF_EXP_ONE) begin
      cls_nxt = CLS_SAT;
    end else begin
      cls_nxt = CLS_NORM;
    end
    // x * 255 as x * 256 - x.
    prod_nxt  = {sig_w, 8'b0} - PROD_W'(sig_w);
    shift_nxt = SHIFT_BASE - ex_w;
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      cls1_r  <= cls_nxt;
      prod_r  <= prod_nxt;
      shift_r <= shift_nxt;
    end
  end

  // Stage 2: add half an output LSB and drop the fraction bits.
  always_comb begin
    bias_w    = SUM_W'(1) << (shift_r - EXP_W'(1));
    sum_w     = SUM_W'(prod_r) + bias_w;
    shifted_w = sum_w >> shift_r;
    quot_nxt  = shifted_w[QUOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      cls2_r <= cls1_r;
      quot_r <= quot_nxt;
    end
  end

  // Stage 3: apply the special cases and clamp to the byte range.
  always_comb begin
    case (cls2_r)
      CLS_ZERO: byte_nxt = '0;
      CLS_SAT:  byte_nxt = UNORM8_MAX;
      CLS_NORM: begin
        if (quot_r > QUOT_W'(UNORM8_MAX)) begin
          byte_nxt = UNORM8_MAX;
        end else begin
          byte_nxt = quot_r[BYTE_W-1:0];
        end
      end
      default:  byte_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_o = byte_r;

endmodule

`default_nettype wire

>>> rtl/half_rgba_to_unorm8_core.sv
// Top level: four-channel binary16 to unorm8 pixel converter with a three-stage pipeline.
// An accepted input transaction moves through stages 1, 2 and 3 to out_valid.
// Throughput is one pixel per cycle while out_stall is low; each of the three stages holds one pixel.
// A stage loads whenever it is empty or the stage after it moves, so bubbles close up.
// rst_n is synchronous and active low; it empties all stages, and payload is not reset.
`default_nettype none

module half_rgba_to_unorm8_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire h2u_pkg::h2u_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output h2u_pkg::h2u_out_t      out_data
);
  import h2u_pkg::*;

  logic     v1_r, v2_r, v3_r;
  logic     v1_nxt, v2_nxt, v3_nxt;
  logic     rdy1, rdy2, rdy3;
  h2u_adv_t adv;

  assign rdy3 = !v3_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  assign in_stall  = !rdy1;
  assign out_valid = v3_r;

  h2u_lane u_red (
    .clk    (clk),
    .adv    (adv),
    .half_i (in_data.red_half),
    .byte_o (out_data.red_byte)
  );

  h2u_lane u_green (
    .clk    (clk),
    .adv    (adv),
    .half_i (in_data.green_half),
    .byte_o (out_data.green_byte)
  );

  h2u_lane u_blue (
    .clk    (clk),
    .adv    (adv),
    .half_i (in_data.blue_half),
    .byte_o (out_data.blue_byte)
  );

  h2u_lane u_alpha (
    .clk    (clk),
    .adv    (adv),
    .half_i (in_data.alpha_half),
    .byte_o (out_data.alpha_byte)
  );

  // An accepted transaction occupies the first stage in the next cycle.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted transaction did not enter stage 1");

  // A pixel in stage 1 that may advance reaches stage 2.
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && rdy2 |=> v2_r)
    else $error("stage 1 pixel lost on advance");

  // A pixel in stage 2 that may advance becomes the output.
  a_s2_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && rdy3 |=> out_valid)
    else $error("stage 2 pixel lost on advance");

  // Input is only held off while the whole pipeline is full and out_stall is high.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> test/tb_half_rgba_to_unorm8_core.sv
// Testbench for the half-float RGBA to unorm8 pixel converter.
`timescale 1ns / 100ps

module tb_half_rgba_to_unorm8_core;
  import h2u_pkg::*;

  // Notable binary16 patterns.
  localparam logic [HALF_W-1:0] HALF_POS_ZERO    = 16'h0000;
  localparam logic [HALF_W-1:0] HALF_NEG_ZERO    = 16'h8000;
  localparam logic [HALF_W-1:0] HALF_MIN_SUBNORM = 16'h0001;
  localparam logic [HALF_W-1:0] HALF_MAX_SUBNORM = 16'h03FF;
  localparam logic [HALF_W-1:0] HALF_MIN_NORMAL  = 16'h0400;
  localparam logic [HALF_W-1:0] HALF_HALF        = 16'h3800;
  localparam logic [HALF_W-1:0] HALF_BELOW_ONE   = 16'h3BFF;
  localparam logic [HALF_W-1:0] HALF_ONE         = 16'h3C00;
  localparam logic [HALF_W-1:0] HALF_TWO         = 16'h4000;
  localparam logic [HALF_W-1:0] HALF_MAX_FINITE  = 16'h7BFF;
  localparam logic [HALF_W-1:0] HALF_POS_INF     = 16'h7C00;
  localparam logic [HALF_W-1:0] HALF_NEG_INF     = 16'hFC00;
  localparam logic [HALF_W-1:0] HALF_QUIET_NAN   = 16'h7E00;
  localparam logic [HALF_W-1:0] HALF_NEG_NAN     = 16'hFE01;
  localparam logic [HALF_W-1:0] HALF_NEG_ONE     = 16'hBC00;
  localparam logic [HALF_W-1:0] HALF_ALL_ONES    = 16'hFFFF;
  localparam int unsigned NUM_SPECIALS = 16;
  localparam int unsigned RANDOM_PIXELS = 2000;
  localparam int unsigned TOTAL_PIXELS = NUM_SPECIALS + RANDOM_PIXELS;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_PRINTED = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  h2u_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  h2u_out_t out_data;

  // Pixels waiting to be sent, and the predicted result of every accepted pixel,
  // indexed by the order of acceptance.
  h2u_in_t pending_pixels[TOTAL_PIXELS];
  h2u_out_t expected_bytes[TOTAL_PIXELS];
  h2u_out_t next_expected;
  logic [HALF_W-1:0] special_halves[NUM_SPECIALS];

  int unsigned total_pixels = 0;
  int unsigned directed_pixels;
  int unsigned send_index = 0;
  int unsigned pixels_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  bit in_fire = 1'b0;
  bit steady_run;

  half_rgba_to_unorm8_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Exact fixed-point conversion of one channel: clamp to [0,1], scale by 255,
  // round half away from zero.
  function automatic logic [BYTE_W-1:0] scale_half_channel(logic [HALF_W-1:0] h);
    logic [EXP_W-1:0] ex;
    logic [MANT_W-1:0] mant;
    logic [EXP_W-1:0] shift;
    logic [SUM_W-1:0] scaled;
    ex = h[14:10];
    mant = h[MANT_W-1:0];
    if (ex == HALF_EXP_ALL_ONES) begin
      return (mant != '0 || h[HALF_W-1]) ? '0 : UNORM8_MAX;
    end
    if (h[HALF_W-1] || ex == HALF_EXP_ZERO) return '0;
    if (ex >= HALF_EXP_ONE) return UNORM8_MAX;
    shift = SHIFT_BASE - ex;
    scaled = SUM_W'({1'b1, mant}) * SUM_W'(UNORM8_MAX);
    scaled = scaled + (SUM_W'(1) << (shift - 1'b1));
    scaled = scaled >> shift;
    if (scaled > SUM_W'(UNORM8_MAX)) scaled = SUM_W'(UNORM8_MAX);
    return scaled[BYTE_W-1:0];
  endfunction

  function automatic h2u_out_t convert_pixel(h2u_in_t px);
    h2u_out_t bytes;
    bytes.red_byte   = scale_half_channel(px.red_half);
    bytes.green_byte = scale_half_channel(px.green_half);
    bytes.blue_byte  = scale_half_channel(px.blue_half);
    bytes.alpha_byte = scale_half_channel(px.alpha_half);
    return bytes;
  endfunction

  // Mostly in-range normals, where the rounding logic does its work.
  function automatic logic [HALF_W-1:0] random_half();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return {1'b0, EXP_W'($urandom_range(1, 14)), MANT_W'($urandom)};
    if (roll < 8) return HALF_W'($urandom);
    if (roll < 9) return special_halves[$urandom_range(0, NUM_SPECIALS - 1)];
    return {1'b0, EXP_W'(14), MANT_W'($urandom)};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_run) return 0;
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < MAX_PRINTED) $display("%0d ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_byte(string lane, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s byte of result %0d is %0d, expected %0d",
                                lane, results_seen, got, want));
    end
  endtask

  // Both sides run without gaps for a while in the middle of the random part.
  assign steady_run = (pixels_accepted >= 900 && pixels_accepted < 1200);

  // Results are checked before this edge's input transaction is booked.
  always @(posedge clk) begin
    in_fire = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (results_seen >= pixels_accepted) begin
          report_mismatch("result arrived with no pixel outstanding");
        end else begin
          next_expected = expected_bytes[results_seen];
          check_byte("red", out_data.red_byte, next_expected.red_byte);
          check_byte("green", out_data.green_byte, next_expected.green_byte);
          check_byte("blue", out_data.blue_byte, next_expected.blue_byte);
          check_byte("alpha", out_data.alpha_byte, next_expected.alpha_byte);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        if (pixels_accepted < TOTAL_PIXELS) begin
          expected_bytes[pixels_accepted] = convert_pixel(in_data);
        end else begin
          report_mismatch("more input transactions accepted than were sent");
        end
        pixels_accepted++;
        in_fire = 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (send_index < total_pixels) begin
        in_data <= pending_pixels[send_index];
        in_valid <= 1'b1;
        send_index++;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the pipeline
  // while the sender keeps offering pixels.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && pixels_accepted >= 400) begin
        out_stall <= 1'b1;
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    h2u_in_t px;
    int unsigned fill_count;
    fill_count = 0;
    special_halves = '{HALF_POS_ZERO, HALF_NEG_ZERO, HALF_MIN_SUBNORM, HALF_MAX_SUBNORM,
                       HALF_MIN_NORMAL, HALF_HALF, HALF_BELOW_ONE, HALF_ONE,
                       HALF_TWO, HALF_MAX_FINITE, HALF_POS_INF, HALF_NEG_INF,
                       HALF_QUIET_NAN, HALF_NEG_NAN, HALF_NEG_ONE, HALF_ALL_ONES};
    // Rotated so that every special pattern lands in every channel.
    for (int i = 0; i < NUM_SPECIALS; i++) begin
      px.red_half   = special_halves[i];
      px.green_half = special_halves[(i + 5) % NUM_SPECIALS];
      px.blue_half  = special_halves[(i + 10) % NUM_SPECIALS];
      px.alpha_half = special_halves[(i + 15) % NUM_SPECIALS];
      pending_pixels[fill_count] = px;
      fill_count++;
    end
    directed_pixels = fill_count;
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      px.red_half   = random_half();
      px.green_half = random_half();
      px.blue_half  = random_half();
      px.alpha_half = random_half();
      pending_pixels[fill_count] = px;
      fill_count++;
    end
    total_pixels = fill_count;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pixels_accepted == total_pixels);
    wait (results_seen >= total_pixels);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_seen < pixels_accepted) begin
      report_mismatch($sformatf("%0d results never arrived", pixels_accepted - results_seen));
    end

    $display("Converted %0d pixels (%0d directed, %0d random), %0d results checked.",
             total_pixels, directed_pixels, RANDOM_PIXELS, results_seen);
    $display("Output was held off for %0d cycles once; %0d mismatches found.",
             HOLD_OFF_CYCLES, error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d of %0d results seen.", results_seen, total_pixels);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
